>>> design/ptts_pkg.sv
// Package for the periodic task tick scheduler: sizes, request and status codes,
// the controller state type and the status bundle of the serial remainder unit.
// Depends on nothing; the other files of the block, all but ptts_ram, refer to it by scoped names.
package ptts_pkg;

   localparam int NUM_SLOTS    = 16;
   localparam int SLOT_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int IDX_W        = $clog2(NUM_SLOTS + 1);
   localparam int SLOT_FIELD_W = 4;
   localparam int PER_W        = 16;
   localparam int DLY_W        = 16;
   localparam int ENTRY_W      = PER_W + DLY_W;
   localparam int TICK_W       = 32;
   localparam int MOD_CNT_W    = $clog2(TICK_W + 1);

   // request kinds
   localparam logic REQ_REGISTER = 1'b0;
   localparam logic REQ_TICK     = 1'b1;

   // register status codes
   localparam logic ST_OK   = 1'b0;
   localparam logic ST_FAIL = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_REG,
      S_RD,
      S_CHK,
      S_DIV,
      S_FIRE,
      S_MARK
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic rem_zero;
   } mod_stat_type;

endpackage

>>> design/ptts_if.sv
// Valid/ready channel interfaces for the scheduler's request and response sides.
// Depends on ptts_pkg for the field widths.
interface ptts_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  req_type;
   logic [ptts_pkg::SLOT_FIELD_W-1:0]     slot;
   logic [ptts_pkg::PER_W-1:0]            period;
   logic [ptts_pkg::DLY_W-1:0]            first_delay;

   modport source (output valid, req_type, slot, period, first_delay, input ready);
   modport sink   (input valid, req_type, slot, period, first_delay, output ready);
endinterface

interface ptts_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  reg_status;
   logic                                  fire_valid;
   logic [ptts_pkg::SLOT_FIELD_W-1:0]     fire_slot;
   logic                                  last;

   modport source (output valid, reg_status, fire_valid, fire_slot, last, input ready);
   modport sink   (input valid, reg_status, fire_valid, fire_slot, last, output ready);
endinterface

>>> design/periodic_task_tick_scheduler_unit.sv
// Periodic task tick scheduler, top level: slot table, walk controller, response register.
// Depends on ptts_pkg, ptts_if (channels), ptts_ram and ptts_mod.

// One request is taken at a time; the request side is ready only while the controller is
// idle, and a finished response may still be waiting in the output register then. For a
// register request the status transfer is loaded in the cycle after acceptance (later if
// the previous response has not been taken). A tick walks the slots in ascending order:
// a free slot is skipped; an occupied slot is read from the table, and while it is still
// counting down its delay the delay is written back less one; a slot with a zero period
// is passed over; an eligible slot gets the bit-serial remainder of the tick count by its
// period and a fire transfer when that remainder is zero. The serial remainder unit, 32
// dividend bits at one bit a cycle, takes the bulk of the walk. Every tick ends with a
// marker transfer (last set) and then advances the tick count, which starts at one and
// wraps at 32 bits. Period and delay live in a small RAM with no reset; occupancy bits
// are flops cleared by reset.
module periodic_task_tick_scheduler_unit (
   input  logic       clock,
   input  logic       reset,
   ptts_req_if.sink   req_chan,
   ptts_rsp_if.source rsp_chan
);

   ptts_pkg::state_type state_ff, state_in;

   // latched request
   logic [ptts_pkg::SLOT_FIELD_W-1:0] item_slot_ff, item_slot_in;
   logic [ptts_pkg::PER_W-1:0]        item_period_ff, item_period_in;
   logic [ptts_pkg::DLY_W-1:0]        item_delay_ff, item_delay_in;

   // walk state
   logic [ptts_pkg::IDX_W-1:0]        idx_ff, idx_in;
   logic [ptts_pkg::NUM_SLOTS-1:0]    slot_used_ff, slot_used_in;
   logic [ptts_pkg::TICK_W-1:0]       tick_count_ff, tick_count_in;

   // response register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_status_ff, rsp_status_in;
   logic                              rsp_fire_ff, rsp_fire_in;
   logic [ptts_pkg::SLOT_FIELD_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic                              rsp_last_ff, rsp_last_in;

   // table RAM and remainder unit hookup
   logic                              ram_wr_en;
   logic [ptts_pkg::SLOT_W-1:0]       ram_wr_addr;
   logic [ptts_pkg::ENTRY_W-1:0]      ram_wr_data;
   logic                              ram_rd_en;
   logic [ptts_pkg::ENTRY_W-1:0]      ram_rd_data;
   logic [ptts_pkg::PER_W-1:0]        ent_period;
   logic [ptts_pkg::DLY_W-1:0]        ent_delay;
   logic                              mod_start;
   ptts_pkg::mod_stat_type            mod_stat;

   logic                              req_xfer;
   logic                              out_free;
   logic [ptts_pkg::SLOT_W-1:0]       used_addr;
   logic                              used_bit;
   logic                              slot_in_range;
   logic                              walk_end;

   assign req_xfer = req_chan.valid && req_chan.ready;
   // output register can take a new transfer this cycle
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // single read port on the occupancy bits: request slot while registering, else walk index
   assign used_addr     = (state_ff == ptts_pkg::S_REG) ? ptts_pkg::SLOT_W'(item_slot_ff)
                                                        : idx_ff[ptts_pkg::SLOT_W-1:0];
   assign used_bit      = slot_used_ff[used_addr];
   assign slot_in_range = (int'(item_slot_ff) < ptts_pkg::NUM_SLOTS);
   assign walk_end      = (idx_ff == ptts_pkg::IDX_W'(ptts_pkg::NUM_SLOTS));

   assign ent_period = ram_rd_data[ptts_pkg::ENTRY_W-1:ptts_pkg::DLY_W];
   assign ent_delay  = ram_rd_data[ptts_pkg::DLY_W-1:0];

   ptts_ram #(
      .WIDTH (ptts_pkg::ENTRY_W),
      .DEPTH (ptts_pkg::NUM_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff[ptts_pkg::SLOT_W-1:0]),
      .rd_data (ram_rd_data)
   );

   ptts_mod u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (tick_count_ff),
      .divisor  (ent_period),
      .stat     (mod_stat)
   );

   always_comb begin
      state_in       = state_ff;
      item_slot_in   = item_slot_ff;
      item_period_in = item_period_ff;
      item_delay_in  = item_delay_ff;
      idx_in         = idx_ff;
      slot_used_in   = slot_used_ff;
      tick_count_in  = tick_count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_fire_in    = rsp_fire_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_last_in    = rsp_last_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = idx_ff[ptts_pkg::SLOT_W-1:0];
      ram_wr_data    = {ent_period, ent_delay - 1'b1};
      ram_rd_en      = 1'b0;
      mod_start      = 1'b0;

      case (state_ff)
         ptts_pkg::S_IDLE: begin
            if (req_xfer) begin
               item_slot_in   = req_chan.slot;
               item_period_in = req_chan.period;
               item_delay_in  = req_chan.first_delay;
               idx_in         = '0;
               state_in       = (req_chan.req_type == ptts_pkg::REQ_REGISTER)
                                ? ptts_pkg::S_REG : ptts_pkg::S_RD;
            end
         end
         ptts_pkg::S_REG: begin
            if (out_free) begin
               // range is checked before occupancy
               rsp_status_in = ptts_pkg::ST_FAIL;
               if (slot_in_range && !used_bit) begin
                  slot_used_in[used_addr] = 1'b1;
                  ram_wr_en     = 1'b1;
                  ram_wr_addr   = used_addr;
                  ram_wr_data   = {item_period_ff, item_delay_ff};
                  rsp_status_in = ptts_pkg::ST_OK;
               end
               rsp_valid_in = 1'b1;
               rsp_fire_in  = 1'b0;
               rsp_slot_in  = '0;
               rsp_last_in  = 1'b1;
               state_in     = ptts_pkg::S_IDLE;
            end
         end
         ptts_pkg::S_RD: begin
            if (walk_end) begin
               state_in = ptts_pkg::S_MARK;
            end else if (!used_bit) begin
               idx_in = idx_ff + 1'b1;
            end else begin
               ram_rd_en = 1'b1;
               state_in  = ptts_pkg::S_CHK;
            end
         end
         ptts_pkg::S_CHK: begin
            if (ent_delay != '0) begin
               // still counting down: write back delay - 1
               ram_wr_en = 1'b1;
               idx_in    = idx_ff + 1'b1;
               state_in  = ptts_pkg::S_RD;
            end else if (ent_period == '0) begin
               idx_in   = idx_ff + 1'b1;
               state_in = ptts_pkg::S_RD;
            end else begin
               mod_start = 1'b1;
               state_in  = ptts_pkg::S_DIV;
            end
         end
         ptts_pkg::S_DIV: begin
            if (mod_stat.done) begin
               if (mod_stat.rem_zero) begin
                  state_in = ptts_pkg::S_FIRE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ptts_pkg::S_RD;
               end
            end
         end
         ptts_pkg::S_FIRE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ptts_pkg::ST_OK;
               rsp_fire_in   = 1'b1;
               rsp_slot_in   = ptts_pkg::SLOT_FIELD_W'(idx_ff);
               rsp_last_in   = 1'b0;
               idx_in        = idx_ff + 1'b1;
               state_in      = ptts_pkg::S_RD;
            end
         end
         ptts_pkg::S_MARK: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ptts_pkg::ST_OK;
               rsp_fire_in   = 1'b0;
               rsp_slot_in   = '0;
               rsp_last_in   = 1'b1;
               tick_count_in = tick_count_ff + 1'b1;
               state_in      = ptts_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ptts_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptts_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_used_ff  <= '0;
         tick_count_ff <= ptts_pkg::TICK_W'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         slot_used_ff  <= slot_used_in;
         tick_count_ff <= tick_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      item_slot_ff   <= item_slot_in;
      item_period_ff <= item_period_in;
      item_delay_ff  <= item_delay_in;
      idx_ff         <= idx_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_fire_ff    <= rsp_fire_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign req_chan.ready      = (state_ff == ptts_pkg::S_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.reg_status = rsp_status_ff;
   assign rsp_chan.fire_valid = rsp_fire_ff;
   assign rsp_chan.fire_slot  = rsp_slot_ff;
   assign rsp_chan.last       = rsp_last_ff;

   // tick count advances exactly when the marker transfer is loaded
   a_tick_adv: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ptts_pkg::S_MARK && out_free)
      |=> (tick_count_ff == $past(tick_count_ff) + 1'b1))
      else $error("tick count did not advance with marker");

   // waiting on the remainder unit only while it is working or reporting
   a_div_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ptts_pkg::S_DIV) |-> (mod_stat.busy || mod_stat.done))
      else $error("remainder wait with idle unit");

   // a fire transfer never carries the last marker
   a_fire_form: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ptts_pkg::S_FIRE && out_free)
      |=> (rsp_valid_ff && rsp_fire_ff && !rsp_last_ff))
      else $error("malformed fire transfer");

   // occupied slots are never released
   a_used_keep: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ((slot_used_ff & $past(slot_used_ff)) == $past(slot_used_ff)))
      else $error("slot occupancy cleared");

endmodule

>>> design/ptts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; holds the period and delay of each task slot.
module ptts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/ptts_mod.sv
// Bit-serial remainder unit: tick count modulo a slot period, one dividend bit per cycle.
// Depends on ptts_pkg for widths and the status bundle.
module ptts_mod (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ptts_pkg::TICK_W-1:0]   dividend,
   input  logic [ptts_pkg::PER_W-1:0]    divisor,
   output ptts_pkg::mod_stat_type        stat
);

   logic [ptts_pkg::TICK_W-1:0]    shift_ff, shift_in;
   logic [ptts_pkg::PER_W-1:0]     rem_ff, rem_in;
   logic [ptts_pkg::PER_W-1:0]     div_ff, div_in;
   logic [ptts_pkg::MOD_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [ptts_pkg::PER_W:0]       rem_shift;
   logic [ptts_pkg::PER_W:0]       diff;

   // restoring step: bring in the next dividend bit, subtract if it fits
   assign rem_shift = {rem_ff, shift_ff[ptts_pkg::TICK_W-1]};
   assign diff      = rem_shift - {1'b0, div_ff};

   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = dividend;
         div_in   = divisor;
         rem_in   = '0;
         cnt_in   = ptts_pkg::MOD_CNT_W'(ptts_pkg::TICK_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = {shift_ff[ptts_pkg::TICK_W-2:0], 1'b0};
         rem_in   = (rem_shift >= {1'b0, div_ff}) ? diff[ptts_pkg::PER_W-1:0]
                                                  : rem_shift[ptts_pkg::PER_W-1:0];
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == ptts_pkg::MOD_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      cnt_ff   <= cnt_in;
   end

   assign stat.busy     = busy_ff;
   assign stat.done     = done_ff;
   assign stat.rem_zero = (rem_ff == '0);

endmodule

>>> dv/periodic_task_tick_scheduler_unit_test.sv
`timescale 1ns / 100ps
// Self-checking bench for periodic_task_tick_scheduler_unit: slot claims and ticks.
// A directed table, then random traffic, checked against a local scheduler predictor.
// Depends on ptts_pkg, the ptts_req_if / ptts_rsp_if channels and the scheduler RTL.
module periodic_task_tick_scheduler_unit_test;

   localparam int RANDOM_ITEMS = 330;
   localparam int QUIET_LIMIT  = 5000;   // cycles with no transfer on either side
   localparam int DRAIN_CYCLES = 64;

   typedef struct packed {
      logic                              kind;
      logic [ptts_pkg::SLOT_FIELD_W-1:0] slot;
      logic [ptts_pkg::PER_W-1:0]        period;
      logic [ptts_pkg::DLY_W-1:0]        first_delay;
   } sched_req_type;

   typedef struct packed {
      logic                              reg_status;
      logic                              fire_valid;
      logic [ptts_pkg::SLOT_FIELD_W-1:0] fire_slot;
      logic                              last;
   } sched_rsp_type;

   // one row of the directed table; pinned rows carry their expected status
   typedef struct packed {
      sched_req_type req;
      logic          pinned;
      logic          pinned_status;
   } plan_row_type;

   typedef enum int {SINK_FREE, SINK_COIN, SINK_MASK} sink_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ptts_req_if req_chan ();
   ptts_rsp_if rsp_chan ();

   periodic_task_tick_scheduler_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Scheduler predictor: its own copy of the slot table and the tick counter.
   // ---------------------------------------------------------------------------
   logic                        slot_taken [ptts_pkg::NUM_SLOTS];
   logic [ptts_pkg::PER_W-1:0]  slot_per   [ptts_pkg::NUM_SLOTS];
   logic [ptts_pkg::DLY_W-1:0]  slot_wait  [ptts_pkg::NUM_SLOTS];
   logic [ptts_pkg::TICK_W-1:0] tick_now;

   sched_rsp_type walk_out [0:ptts_pkg::NUM_SLOTS];   // results of the latest item, in order
   sched_rsp_type owed_results [$];                   // results the scheduler still owes us

   int mismatch_count = 0;
   int quiet_cycles   = 0;

   sched_rsp_type seen_rsp;
   sched_rsp_type due_rsp;

   // Applies one request to the predictor; fills walk_out and returns the count.
   function automatic int schedule_outcome(input sched_req_type r);
      int n;
      int i;
      n = 0;
      if (r.kind == ptts_pkg::REQ_REGISTER) begin
         walk_out[0] = {ptts_pkg::ST_FAIL, 1'b0, {ptts_pkg::SLOT_FIELD_W{1'b0}}, 1'b1};
         // range is checked before occupancy
         if (int'(r.slot) < ptts_pkg::NUM_SLOTS && !slot_taken[r.slot]) begin
            slot_taken[r.slot]     = 1'b1;
            slot_per[r.slot]       = r.period;
            slot_wait[r.slot]      = r.first_delay;
            walk_out[0].reg_status = ptts_pkg::ST_OK;
         end
         return 1;
      end
      for (i = 0; i < ptts_pkg::NUM_SLOTS; i++) begin
         if (slot_taken[i]) begin
            if (slot_wait[i] != '0) begin
               slot_wait[i] = slot_wait[i] - 1'b1;
            end else if (slot_per[i] != '0 && (tick_now % slot_per[i]) == '0) begin
               walk_out[n] = {ptts_pkg::ST_OK, 1'b1, ptts_pkg::SLOT_FIELD_W'(i), 1'b0};
               n++;
            end
         end
      end
      walk_out[n] = {ptts_pkg::ST_OK, 1'b0, {ptts_pkg::SLOT_FIELD_W{1'b0}}, 1'b1};
      n++;
      tick_now = tick_now + 1'b1;
      return n;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   // ---------------------------------------------------------------------------
   // Request side. Called at a falling edge, returns at the falling edge after
   // the transfer, so a following item keeps valid high with no dip.
   // ---------------------------------------------------------------------------
   task automatic transfer_request(input sched_req_type r, input logic pinned,
                                   input logic pinned_status);
      int n;
      int j;
      req_chan.valid       <= 1'b1;
      req_chan.req_type    <= r.kind;
      req_chan.slot        <= r.slot;
      req_chan.period      <= r.period;
      req_chan.first_delay <= r.first_delay;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      n = schedule_outcome(r);
      if (pinned) begin
         // table rows give a single result: register status, or a bare marker
         n = 1;
         walk_out[0] = {(r.kind == ptts_pkg::REQ_REGISTER) ? pinned_status : ptts_pkg::ST_OK,
                        1'b0, {ptts_pkg::SLOT_FIELD_W{1'b0}}, 1'b1};
      end
      for (j = 0; j < n; j++) owed_results.push_back(walk_out[j]);
      @(negedge clock);
   endtask

   task automatic idle_requests(input int cycles);
      if (cycles > 0) begin
         req_chan.valid <= 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   // hold off the sender until the scheduler has paid out everything owed
   task automatic settle_outputs();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (owed_results.size() != 0);
   endtask

   function automatic plan_row_type plan_row(input logic kind, input int slot, input int per,
                                             input int dly, input logic pinned,
                                             input logic st);
      plan_row_type p;
      p.req.kind        = kind;
      p.req.slot        = ptts_pkg::SLOT_FIELD_W'(slot);
      p.req.period      = ptts_pkg::PER_W'(per);
      p.req.first_delay = ptts_pkg::DLY_W'(dly);
      p.pinned          = pinned;
      p.pinned_status   = st;
      return p;
   endfunction

   // Mostly ticks; claims carry small periods and delays so that slots
   // actually fire within the run, with the odd full-range value for coverage.
   function automatic sched_req_type random_request();
      sched_req_type r;
      int pick;
      r.slot        = ptts_pkg::SLOT_FIELD_W'($urandom_range(0, 15));
      r.period      = ptts_pkg::PER_W'($urandom);
      r.first_delay = ptts_pkg::DLY_W'($urandom);
      if ($urandom_range(0, 99) < 25) begin
         r.kind = ptts_pkg::REQ_REGISTER;
         pick   = $urandom_range(0, 9);
         if (pick == 0)
            r.period = '0;
         else if (pick < 7)
            r.period = ptts_pkg::PER_W'($urandom_range(1, 8));
         pick = $urandom_range(0, 9);
         if (pick < 5)
            r.first_delay = '0;
         else if (pick < 8)
            r.first_delay = ptts_pkg::DLY_W'($urandom_range(1, 6));
      end else begin
         r.kind = ptts_pkg::REQ_TICK;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Response side: ready follows a pattern, redrawn each time its phase counter runs out
   // - always ready, a biased coin, or a rotating mask.
   // ---------------------------------------------------------------------------
   sink_mode_type sink_mode   = SINK_FREE;
   logic [7:0]    sink_mask   = 8'hff;
   int            sink_phase  = 0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (sink_phase == 0) begin
            sink_mode  = sink_mode_type'($urandom_range(0, 2));
            sink_mask  = 8'($urandom_range(1, 255));
            sink_phase = $urandom_range(20, 80);
         end
         sink_phase--;
         case (sink_mode)
            SINK_FREE: rsp_chan.ready <= 1'b1;
            SINK_COIN: rsp_chan.ready <= ($urandom_range(0, 9) < 6);
            default: begin
               rsp_chan.ready <= sink_mask[0];
               sink_mask = {sink_mask[0], sink_mask[7:1]};
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Checker and watchdog, on the rising edge.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] watchdog: no transfer for %0d cycles", $time, quiet_cycles);
            $display("periodic_task_tick_scheduler_unit regression: fail");
            $finish;
         end else if (rsp_chan.valid && rsp_chan.ready) begin
            seen_rsp = {rsp_chan.reg_status, rsp_chan.fire_valid, rsp_chan.fire_slot,
                        rsp_chan.last};
            if (owed_results.size() == 0) begin
               report_mismatch($sformatf("result %h with nothing outstanding", seen_rsp));
            end else begin
               due_rsp = owed_results.pop_front();
               if (seen_rsp.reg_status !== due_rsp.reg_status)
                  report_mismatch($sformatf("reg_status got %b, expected %b",
                                            seen_rsp.reg_status, due_rsp.reg_status));
               if (seen_rsp.fire_valid !== due_rsp.fire_valid)
                  report_mismatch($sformatf("fire_valid got %b, expected %b",
                                            seen_rsp.fire_valid, due_rsp.fire_valid));
               if (seen_rsp.fire_slot !== due_rsp.fire_slot)
                  report_mismatch($sformatf("fire_slot got %0d, expected %0d",
                                            seen_rsp.fire_slot, due_rsp.fire_slot));
               if (seen_rsp.last !== due_rsp.last)
                  report_mismatch($sformatf("last got %b, expected %b",
                                            seen_rsp.last, due_rsp.last));
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------
   plan_row_type directed_plan [$];

   initial begin
      int k;
      int burst_left;
      plan_row_type p;

      req_chan.valid       = 1'b0;
      req_chan.req_type    = ptts_pkg::REQ_REGISTER;
      req_chan.slot        = '0;
      req_chan.period      = '0;
      req_chan.first_delay = '0;

      for (k = 0; k < ptts_pkg::NUM_SLOTS; k++) begin
         slot_taken[k] = 1'b0;
         slot_per[k]   = '0;
         slot_wait[k]  = '0;
      end
      tick_now = ptts_pkg::TICK_W'(1);

      // Directed table. Pinned rows: claim status, or a bare marker on an empty tick.
      directed_plan.push_back(plan_row(ptts_pkg::REQ_TICK, 0, 0, 0, 1'b1,
                                       ptts_pkg::ST_OK));   // empty table
      directed_plan.push_back(plan_row(ptts_pkg::REQ_REGISTER, 0, 1, 0, 1'b1,
                                       ptts_pkg::ST_OK));
      directed_plan.push_back(plan_row(ptts_pkg::REQ_REGISTER, 0, 5, 5, 1'b1,
                                       ptts_pkg::ST_FAIL)); // taken
      directed_plan.push_back(plan_row(ptts_pkg::REQ_REGISTER, 3, 0, 0, 1'b1,
                                       ptts_pkg::ST_OK));   // zero period
      directed_plan.push_back(plan_row(ptts_pkg::REQ_TICK, 0, 0, 0, 1'b0, ptts_pkg::ST_OK));
      directed_plan.push_back(plan_row(ptts_pkg::REQ_REGISTER, 15, 65535, 65535, 1'b1,
                                       ptts_pkg::ST_OK));
      directed_plan.push_back(plan_row(ptts_pkg::REQ_REGISTER, 15, 0, 0, 1'b1,
                                       ptts_pkg::ST_FAIL));
      directed_plan.push_back(plan_row(ptts_pkg::REQ_REGISTER, 7, 2, 3, 1'b1,
                                       ptts_pkg::ST_OK));
      directed_plan.push_back(plan_row(ptts_pkg::REQ_REGISTER, 5, 3, 0, 1'b1,
                                       ptts_pkg::ST_OK));
      directed_plan.push_back(plan_row(ptts_pkg::REQ_REGISTER, 10, 1, 1, 1'b1,
                                       ptts_pkg::ST_OK));
      for (k = 0; k < 6; k++)
         directed_plan.push_back(plan_row(ptts_pkg::REQ_TICK, 0, 0, 0, 1'b0,
                                          ptts_pkg::ST_OK));
      // tick with every payload bit set: fields must be ignored
      directed_plan.push_back(plan_row(ptts_pkg::REQ_TICK, 15, 65535, 65535, 1'b0,
                                       ptts_pkg::ST_OK));
      directed_plan.push_back(plan_row(ptts_pkg::REQ_REGISTER, 12, 65535, 0, 1'b1,
                                       ptts_pkg::ST_OK));
      directed_plan.push_back(plan_row(ptts_pkg::REQ_REGISTER, 9, 0, 2, 1'b1,
                                       ptts_pkg::ST_OK));
      directed_plan.push_back(plan_row(ptts_pkg::REQ_REGISTER, 9, 65535, 65535, 1'b1,
                                       ptts_pkg::ST_FAIL));
      for (k = 0; k < 4; k++)
         directed_plan.push_back(plan_row(ptts_pkg::REQ_TICK, 0, 0, 0, 1'b0,
                                          ptts_pkg::ST_OK));

      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_plan[k]) begin
         p = directed_plan[k];
         transfer_request(p.req, p.pinned, p.pinned_status);
      end
      settle_outputs();

      // Random traffic in bursts; now and then the sender waits for a full drain.
      burst_left = 0;
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         if (burst_left == 0) begin
            idle_requests($urandom_range(0, 8));
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
         end
         if (k % 70 == 35)
            settle_outputs();
         transfer_request(random_request(), 1'b0, ptts_pkg::ST_OK);
         burst_left--;
      end
      req_chan.valid <= 1'b0;

      while (owed_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("periodic_task_tick_scheduler_unit regression: pass");
      else
         $display("periodic_task_tick_scheduler_unit regression: fail");
      $finish;
   end

endmodule
